>>> hw/rtl/gb3_pkg.sv
package gb3_pkg;

	localparam int MAX_SIDE = 4096;
	localparam int SIDE_W   = 13;
	localparam int COORD_W  = 12;
	localparam int PIX_W    = 8;
	localparam int SUM_W    = 12;
	localparam int NRES     = 4;

	// Reciprocal of nine in 16 fractional bits; exact floor for sums below 2296.
	localparam logic [12:0] DIV9_MUL = 13'd7282;

	typedef enum logic [1:0] {
		SEL_MID  = 2'd0,
		SEL_LOW  = 2'd1,
		SEL_HIGH = 2'd2
	} sel_t;

	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		sel_t               rsel;
		sel_t               csel;
		logic               corner;
		logic               last;
		logic               done;
	} res_desc_t;

	typedef struct packed {
		win_t                       win;
		logic [NRES-1:0]            mask;
		res_desc_t [NRES-1:0]       desc;
	} grp_t;

	function automatic logic [1:0] tap_idx(sel_t s, logic [1:0] i);
		case (s)
			SEL_LOW:  tap_idx = (i == 2'd0) ? 2'd1 : i;
			SEL_HIGH: tap_idx = (i == 2'd0) ? 2'd1 : 2'd2;
			default:  tap_idx = i;
		endcase
	endfunction

	function automatic logic [1:0] centre_idx(sel_t s);
		centre_idx = (s == SEL_HIGH) ? 2'd2 : 2'd1;
	endfunction

	function automatic logic [1:0] outer_idx(sel_t s);
		case (s)
			SEL_LOW:  outer_idx = 2'd2;
			SEL_HIGH: outer_idx = 2'd1;
			default:  outer_idx = 2'd0;
		endcase
	endfunction

endpackage

>>> hw/rtl/gb3_out.sv
module gb3_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          grp_load,
	input  gb3_pkg::grp_t                 grp,
	output logic                          grp_ready,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [gb3_pkg::PIX_W-1:0]     value,
	output logic [gb3_pkg::COORD_W-1:0]   out_row,
	output logic [gb3_pkg::COORD_W-1:0]   out_col,
	output logic                          last_of_run,
	output logic                          frame_done
);

	gb3_pkg::grp_t               g_q;
	logic [gb3_pkg::NRES-1:0]    g_mask_q;
	logic [1:0]                  idx;
	gb3_pkg::res_desc_t          d;
	logic                        busy;
	logic                        issue;
	logic                        s3_free;
	logic                        out_adv;
	logic [gb3_pkg::PIX_W-1:0]   px;
	logic [gb3_pkg::SUM_W-1:0]   sum_full;
	logic [gb3_pkg::SUM_W-1:0]   sum_corner;
	logic [1:0]                  cr, cc, orr, oc;

	logic                        s3_valid;
	logic [gb3_pkg::SUM_W-1:0]   sum_s3;
	gb3_pkg::res_desc_t          d_s3;
	logic [24:0]                 prod;

	assign busy    = |g_mask_q;
	assign out_adv = !result_valid || result_ready;
	assign s3_free = !s3_valid || out_adv;
	assign issue   = busy && s3_free;
	assign grp_ready = !busy || (issue && $onehot(g_mask_q));

	always_comb begin
		if (g_mask_q[0]) idx = 2'd0;
		else if (g_mask_q[1]) idx = 2'd1;
		else if (g_mask_q[2]) idx = 2'd2;
		else idx = 2'd3;
	end

	assign d = g_q.desc[idx];

	always_comb begin
		sum_full = '0;
		px = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				px = g_q.win[gb3_pkg::tap_idx(d.rsel, 2'(i))][gb3_pkg::tap_idx(d.csel, 2'(j))];
				sum_full = sum_full + (gb3_pkg::SUM_W'(px) << (((i == 1) ? 1 : 0) + ((j == 1) ? 1 : 0)));
			end
		end
	end

	assign cr  = gb3_pkg::centre_idx(d.rsel);
	assign cc  = gb3_pkg::centre_idx(d.csel);
	assign orr = gb3_pkg::outer_idx(d.rsel);
	assign oc  = gb3_pkg::outer_idx(d.csel);
	assign sum_corner = (gb3_pkg::SUM_W'(g_q.win[cr][cc]) << 2)
		+ (gb3_pkg::SUM_W'(g_q.win[cr][oc]) << 1)
		+ (gb3_pkg::SUM_W'(g_q.win[orr][cc]) << 1)
		+ gb3_pkg::SUM_W'(g_q.win[orr][oc]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_mask_q <= '0;
		end else if (grp_load && (|grp.mask)) begin
			g_mask_q <= grp.mask;
		end else if (issue) begin
			g_mask_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load && (|grp.mask)) begin
			g_q <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (s3_free) begin
			s3_valid <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s3 <= d.corner ? sum_corner : sum_full;
			d_s3   <= d;
		end
	end

	assign prod = 25'(sum_s3) * 25'(gb3_pkg::DIV9_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_adv) begin
			result_valid <= s3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s3_valid) begin
			value       <= d_s3.corner ? prod[23:16] : sum_s3[11:4];
			out_row     <= d_s3.row;
			out_col     <= d_s3.col;
			last_of_run <= d_s3.last;
			frame_done  <= d_s3.done;
		end
	end

	a_done_diag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> out_row == out_col)
		else $error("frame_done on a pixel off the diagonal");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s3_valid && !s3_free |=> s3_valid && $stable(sum_s3))
		else $error("stalled sum stage changed");

	a_load_mask: assert property (@(posedge clk) disable iff (!arst_n)
		grp_load && (|grp.mask) |-> grp_ready)
		else $error("group loaded while the previous one is still pending");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> s3_valid)
		else $error("issued result lost before the sum stage");

endmodule

>>> hw/rtl/gaussian_blur_3x3_stream_top.sv
// The first result of a pixel passes the line buffer stage, the group register, the sum stage
// and the output register; further results follow one per cycle while result_ready is high.
// Throughput: one pixel per cycle while each pixel yields at most one result and result_ready
// is high; a pixel with more results holds the shared filter unit until all have issued.
// Reset clears the position counters, the window and the pipeline; the side register resets to
// 4096. The line buffers in block RAM are not cleared and need no clearing pass.
module gaussian_blur_3x3_stream_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gb3_pkg::SIDE_W-1:0]    cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [gb3_pkg::PIX_W-1:0]     pixel,
	input  logic                          frame_start,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [gb3_pkg::PIX_W-1:0]     value,
	output logic [gb3_pkg::COORD_W-1:0]   out_row,
	output logic [gb3_pkg::COORD_W-1:0]   out_col,
	output logic                          last_of_run,
	output logic                          frame_done
);

	logic [gb3_pkg::SIDE_W-1:0]    side_q;
	logic [gb3_pkg::SIDE_W-1:0]    n;
	logic [gb3_pkg::COORD_W-1:0]   nm1;
	logic [gb3_pkg::COORD_W-1:0]   row_q, col_q;
	logic [gb3_pkg::SIDE_W-1:0]    r_in, c_in;
	logic [gb3_pkg::SIDE_W-1:0]    r_nx, c_nx;
	logic                          accept;

	logic [2*gb3_pkg::PIX_W-1:0]   line_mem [gb3_pkg::MAX_SIDE];
	logic [2*gb3_pkg::PIX_W-1:0]   line_rd_s1;
	logic [2*gb3_pkg::PIX_W-1:0]   fwd_data_s1;
	logic                          fwd_s1;
	logic [2*gb3_pkg::PIX_W-1:0]   rd_word;
	logic [2*gb3_pkg::PIX_W-1:0]   wr_word;

	logic                          s1_valid;
	logic                          s1_adv;
	logic [gb3_pkg::PIX_W-1:0]     pixel_s1;
	logic [gb3_pkg::COORD_W-1:0]   row_s1, col_s1;

	gb3_pkg::win_t                 win_q;
	gb3_pkg::win_t                 win_nx;
	gb3_pkg::grp_t                 grp;
	logic                          grp_ready;
	logic [gb3_pkg::NRES-1:0]      v;
	gb3_pkg::sel_t                 rs, cs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= gb3_pkg::SIDE_W'(gb3_pkg::MAX_SIDE);
		end else if (cfg_we) begin
			side_q <= cfg_data;
		end
	end

	always_comb begin
		n = side_q;
		if (n < gb3_pkg::SIDE_W'(3)) n = gb3_pkg::SIDE_W'(3);
		if (n > gb3_pkg::SIDE_W'(gb3_pkg::MAX_SIDE)) n = gb3_pkg::SIDE_W'(gb3_pkg::MAX_SIDE);
	end

	assign nm1 = gb3_pkg::COORD_W'(n - gb3_pkg::SIDE_W'(1));

	always_comb begin
		if (frame_start) begin
			r_in = '0;
			c_in = '0;
		end else begin
			r_in = {1'b0, row_q};
			c_in = {1'b0, col_q};
			if (c_in >= n) begin
				c_in = '0;
				r_in = r_in + gb3_pkg::SIDE_W'(1);
			end
			if (r_in >= n) r_in = '0;
		end
		if (c_in + gb3_pkg::SIDE_W'(1) >= n) begin
			c_nx = '0;
			r_nx = (r_in + gb3_pkg::SIDE_W'(1) >= n) ? '0 : r_in + gb3_pkg::SIDE_W'(1);
		end else begin
			c_nx = c_in + gb3_pkg::SIDE_W'(1);
			r_nx = r_in;
		end
	end

	assign s1_adv      = s1_valid && (grp_ready || !(|grp.mask));
	assign pixel_ready = !s1_valid || s1_adv;
	assign accept      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				row_q <= r_nx[gb3_pkg::COORD_W-1:0];
				col_q <= c_nx[gb3_pkg::COORD_W-1:0];
			end
			if (accept) s1_valid <= 1'b1;
			else if (s1_adv) s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1    <= pixel;
			row_s1      <= r_in[gb3_pkg::COORD_W-1:0];
			col_s1      <= c_in[gb3_pkg::COORD_W-1:0];
			fwd_s1      <= s1_valid && (col_s1 == c_in[gb3_pkg::COORD_W-1:0]);
			fwd_data_s1 <= wr_word;
		end
	end

	// Each word holds the row two back in the upper byte and the row one back in the lower.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_s1 <= line_mem[c_in[gb3_pkg::COORD_W-1:0]];
		end
		if (s1_adv) begin
			line_mem[col_s1] <= wr_word;
		end
	end

	assign rd_word = fwd_s1 ? fwd_data_s1 : line_rd_s1;
	assign wr_word = {rd_word[gb3_pkg::PIX_W-1:0], pixel_s1};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = rd_word[2*gb3_pkg::PIX_W-1:gb3_pkg::PIX_W];
		win_nx[1][2] = rd_word[gb3_pkg::PIX_W-1:0];
		win_nx[2][2] = pixel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_nx;
		end
	end

	assign rs = (row_s1 == gb3_pkg::COORD_W'(1)) ? gb3_pkg::SEL_LOW : gb3_pkg::SEL_MID;
	assign cs = (col_s1 == gb3_pkg::COORD_W'(1)) ? gb3_pkg::SEL_LOW : gb3_pkg::SEL_MID;

	always_comb begin
		v[0] = (row_s1 != '0) && (col_s1 != '0);
		v[1] = v[0] && (col_s1 == nm1);
		v[2] = (row_s1 == nm1) && (col_s1 != '0);
		v[3] = v[2] && (col_s1 == nm1);

		grp.win = win_nx;
		grp.mask = v;

		grp.desc[0].row  = row_s1 - gb3_pkg::COORD_W'(1);
		grp.desc[0].col  = col_s1 - gb3_pkg::COORD_W'(1);
		grp.desc[0].rsel = rs;
		grp.desc[0].csel = cs;
		grp.desc[1].row  = row_s1 - gb3_pkg::COORD_W'(1);
		grp.desc[1].col  = nm1;
		grp.desc[1].rsel = rs;
		grp.desc[1].csel = gb3_pkg::SEL_HIGH;
		grp.desc[2].row  = nm1;
		grp.desc[2].col  = col_s1 - gb3_pkg::COORD_W'(1);
		grp.desc[2].rsel = gb3_pkg::SEL_HIGH;
		grp.desc[2].csel = cs;
		grp.desc[3].row  = nm1;
		grp.desc[3].col  = nm1;
		grp.desc[3].rsel = gb3_pkg::SEL_HIGH;
		grp.desc[3].csel = gb3_pkg::SEL_HIGH;

		for (int k = 0; k < gb3_pkg::NRES; k++) begin
			grp.desc[k].corner = ((grp.desc[k].row == '0) || (grp.desc[k].row == nm1))
				&& ((grp.desc[k].col == '0) || (grp.desc[k].col == nm1));
			grp.desc[k].done = (grp.desc[k].row == nm1) && (grp.desc[k].col == nm1);
			grp.desc[k].last = v[k] && ((v >> (k + 1)) == '0);
		end
	end

	gb3_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_load     (s1_adv),
		.grp          (grp),
		.grp_ready    (grp_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run),
		.frame_done   (frame_done)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(col_s1) && $stable(pixel_s1))
		else $error("stalled line buffer stage changed");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s1_valid |-> s1_adv)
		else $error("pixel accepted over a stalled line buffer stage");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we |=> !s1_valid || ({1'b0, col_s1} < n && {1'b0, row_s1} < n))
		else $error("window position outside the image");

	a_fwd_same: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && fwd_s1 && $past(accept) |-> col_s1 == $past(col_s1))
		else $error("forwarded word from a different column");

endmodule
